@@ design/effect_slot_manager_core_macros.svh @@
// Assertion macros shared by the effect slot manager RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef EFFECT_SLOT_MANAGER_CORE_MACROS_SVH
`define EFFECT_SLOT_MANAGER_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ESM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ESM_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ design/esm_pkg.sv @@
// Package for the effect slot manager: action, status and report codes,
// defaults, and the command and status structs between controller and datapath.
package esm_pkg;
	localparam int ESM_SLOTS       = 16;
	localparam int ESM_MAX_RESULTS = 16;
	localparam int ESM_FIRST_SLOT  = 2;
	localparam int ESM_CNT_W       = $clog2(ESM_MAX_RESULTS + 1);

	localparam logic [7:0]  ESM_TYPE_RST  = 8'd11;
	localparam logic [7:0]  ESM_NO_SLOT   = 8'hFF;
	localparam logic [15:0] ESM_INF_LIMIT = 16'h7FFF;
	localparam logic [15:0] ESM_DUR_HI    = 16'h7F00;
	localparam logic [15:0] ESM_DUR_LO    = 16'h007F;

	localparam logic [2:0] ACT_CREATE   = 3'd0;
	localparam logic [2:0] ACT_FREE     = 3'd1;
	localparam logic [2:0] ACT_FREE_ALL = 3'd2;
	localparam logic [2:0] ACT_START    = 3'd3;
	localparam logic [2:0] ACT_SOLO     = 3'd4;
	localparam logic [2:0] ACT_STOP     = 3'd5;
	localparam logic [2:0] ACT_SET_DUR  = 3'd6;
	localparam logic [2:0] ACT_TICK     = 3'd7;

	localparam logic [1:0] LS_OK       = 2'd0;
	localparam logic [1:0] LS_FULL     = 2'd1;
	localparam logic [1:0] LS_BAD_TYPE = 2'd2;

	localparam logic RK_CREATE = 1'b0;
	localparam logic RK_STATE  = 1'b1;

	typedef struct packed {
		logic load;
		logic exec;
		logic eval;
		logic last_slot;
		logic solo_run;
		logic flush;
	} esm_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic is_solo;
		logic hit;
		logic blk;
	} esm_sts_t;
endpackage

@@ design/esm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/esm_ctrl.sv @@
// Controller state machine of the effect slot manager: sequences execute,
// slot scan, solo start and result flush. Depends on esm_pkg.
module esm_ctrl import esm_pkg::*; #(
	parameter int SLOTS = ESM_SLOTS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	output esm_cmd_t                 cmd,
	input  esm_sts_t                 sts,
	output logic [$clog2(SLOTS)-1:0] scan_idx
);
	localparam int SW = $clog2(SLOTS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_SOLO = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]    state_q;
	logic [SW-1:0] scan_q;
	logic          last;

	assign last          = (scan_q == SW'(SLOTS - 1));
	assign scan_idx      = scan_q;
	assign s_axis_tready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && s_axis_tvalid;
		cmd.exec      = (state_q == S_EXEC);
		cmd.eval      = (state_q == S_EV);
		cmd.last_slot = last;
		cmd.solo_run  = (state_q == S_SOLO);
		cmd.flush     = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= SW'(ESM_FIRST_SLOT);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!sts.blk) begin
						scan_q  <= SW'(ESM_FIRST_SLOT);
						state_q <= sts.need_scan ? S_RD : S_FIN;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (!sts.blk) begin
						if (sts.hit) begin
							state_q <= S_FIN;
						end else if (last) begin
							state_q <= sts.is_solo ? S_SOLO : S_FIN;
						end else begin
							scan_q  <= scan_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_SOLO: begin
					if (!sts.blk) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!sts.blk) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

@@ design/esm_dp.sv @@
// Datapath of the effect slot manager: slot flags, start time and duration RAMs,
// counters, result buffering and output register. Depends on esm_pkg, esm_ram.
`include "effect_slot_manager_core_macros.svh"
module esm_dp import esm_pkg::*; #(
	parameter int SLOTS = ESM_SLOTS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  esm_cmd_t                 cmd,
	output esm_sts_t                 sts,
	input  logic [$clog2(SLOTS)-1:0] scan_idx,
	input  logic [31:0]              s_axis_tdata,
	input  logic [2:0]               s_axis_tuser,
	input  logic                     cfg_we,
	input  logic [7:0]               cfg_wdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [23:0]              m_axis_tdata,
	output logic                     m_axis_tuser,
	output logic                     m_axis_tlast
);
	localparam int SW = $clog2(SLOTS);

	logic [7:0]           max_type_q;
	logic [2:0]           act_q;
	logic [7:0]           idx_q;
	logic [7:0]           type_q;
	logic [15:0]          dval_q;
	logic [SLOTS-1:0]     alloc_q;
	logic [SLOTS-1:0]     play_q;
	logic [6:0]           free_count_q;
	logic [31:0]          time_q;
	logic [ESM_CNT_W-1:0] cnt_q;

	logic       pend_v_q;
	logic       pend_kind_q;
	logic [7:0] pend_slot_q;
	logic       pend_play_q;
	logic [1:0] pend_stat_q;

	logic       out_v_q;
	logic       out_kind_q;
	logic [7:0] out_slot_q;
	logic       out_play_q;
	logic [1:0] out_stat_q;
	logic [6:0] out_free_q;
	logic       out_last_q;

	logic [31:0] st_rd;
	logic [15:0] du_rd;
	logic        st_we;
	logic        du_we;
	logic [15:0] du_wd;
	logic [SW-1:0] wa;

	logic          idx_ok;
	logic [SW-1:0] is;
	logic [SW-1:0] f_idx;
	logic a_set, a_clr, p_set, p_clr, fc_inc, fc_dec, time_inc;
	logic emit_want, emit_req, hit, need_scan, blk, go, take, out_load;
	logic       e_kind;
	logic [7:0] e_slot;
	logic       e_play;
	logic [1:0] e_stat;
	logic [31:0] elapsed;

	assign idx_ok  = (idx_q >= 8'(ESM_FIRST_SLOT)) && (idx_q < 8'(SLOTS));
	assign is      = idx_q[SW-1:0];
	assign elapsed = time_q - st_rd;

	always_comb begin
		a_set = 1'b0; a_clr = 1'b0; p_set = 1'b0; p_clr = 1'b0;
		fc_inc = 1'b0; fc_dec = 1'b0; time_inc = 1'b0;
		st_we = 1'b0; du_we = 1'b0; du_wd = '0;
		emit_want = 1'b0; hit = 1'b0; need_scan = 1'b0;
		e_kind = RK_STATE; e_slot = '0; e_play = 1'b0; e_stat = LS_OK;
		f_idx = scan_idx;
		wa    = scan_idx;
		if (cmd.exec) begin
			f_idx = is;
			wa    = is;
			case (act_q)
				ACT_CREATE: begin
					if (type_q > max_type_q) begin
						emit_want = 1'b1;
						e_kind    = RK_CREATE;
						e_slot    = ESM_NO_SLOT;
						e_stat    = LS_BAD_TYPE;
					end else begin
						need_scan = 1'b1;
					end
				end
				ACT_FREE: begin
					if (idx_ok && alloc_q[is]) begin
						a_clr  = 1'b1;
						p_clr  = 1'b1;
						fc_inc = 1'b1;
					end
				end
				ACT_START: begin
					if (idx_ok && alloc_q[is] && !play_q[is]) begin
						p_set     = 1'b1;
						st_we     = 1'b1;
						emit_want = 1'b1;
						e_slot    = idx_q;
						e_play    = 1'b1;
					end
				end
				ACT_STOP: begin
					if (idx_ok && play_q[is]) begin
						p_clr     = 1'b1;
						st_we     = 1'b1;
						emit_want = 1'b1;
						e_slot    = idx_q;
					end
				end
				ACT_SET_DUR: begin
					if (idx_ok) begin
						du_we = 1'b1;
						if (dval_q >= ESM_INF_LIMIT) begin
							du_wd = 16'h8000;
						end else begin
							du_wd = {1'b0, 15'((dval_q & ESM_DUR_HI) | (dval_q & ESM_DUR_LO))};
						end
					end
				end
				ACT_TICK: begin
					time_inc  = 1'b1;
					need_scan = 1'b1;
				end
				default: begin
					need_scan = 1'b1;
				end
			endcase
		end else if (cmd.eval) begin
			case (act_q)
				ACT_CREATE: begin
					if (!alloc_q[scan_idx]) begin
						a_set     = 1'b1;
						p_clr     = 1'b1;
						du_we     = 1'b1;
						du_wd     = 16'h8000;
						fc_dec    = (free_count_q != '0);
						hit       = 1'b1;
						emit_want = 1'b1;
						e_kind    = RK_CREATE;
						e_slot    = 8'(scan_idx);
					end else if (cmd.last_slot) begin
						emit_want = 1'b1;
						e_kind    = RK_CREATE;
						e_slot    = ESM_NO_SLOT;
						e_stat    = LS_FULL;
					end
				end
				ACT_FREE_ALL: begin
					if (alloc_q[scan_idx] && !play_q[scan_idx]) begin
						a_clr  = 1'b1;
						fc_inc = 1'b1;
					end
				end
				ACT_SOLO: begin
					if (play_q[scan_idx]) begin
						p_clr     = 1'b1;
						st_we     = 1'b1;
						emit_want = 1'b1;
						e_slot    = 8'(scan_idx);
					end
				end
				ACT_TICK: begin
					if (play_q[scan_idx] && !du_rd[15] && (elapsed > {17'd0, du_rd[14:0]})) begin
						p_clr     = 1'b1;
						emit_want = 1'b1;
						e_slot    = 8'(scan_idx);
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.solo_run) begin
			f_idx = is;
			wa    = is;
			if (idx_ok && alloc_q[is] && !play_q[is]) begin
				p_set     = 1'b1;
				st_we     = 1'b1;
				emit_want = 1'b1;
				e_slot    = idx_q;
				e_play    = 1'b1;
			end
		end
	end

	assign emit_req = emit_want && (cnt_q < ESM_CNT_W'(ESM_MAX_RESULTS));
	assign blk      = (emit_req || cmd.flush) && pend_v_q && out_v_q && !m_axis_tready;
	assign go       = !blk;
	assign take     = out_v_q && m_axis_tready;
	assign out_load = pend_v_q && !blk && (emit_req || cmd.flush);

	always_comb begin
		sts           = '0;
		sts.need_scan = need_scan;
		sts.is_solo   = (act_q == ACT_SOLO);
		sts.hit       = hit;
		sts.blk       = blk;
	end

	esm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_start_ram (
		.clk   (clk),
		.we    (st_we && go),
		.waddr (wa),
		.wdata (time_q),
		.raddr (scan_idx),
		.rdata (st_rd)
	);

	esm_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_dur_ram (
		.clk   (clk),
		.we    (du_we && go),
		.waddr (wa),
		.wdata (du_wd),
		.raddr (scan_idx),
		.rdata (du_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= s_axis_tuser;
			idx_q  <= s_axis_tdata[7:0];
			type_q <= s_axis_tdata[15:8];
			dval_q <= s_axis_tdata[31:16];
		end
		if (go && emit_req) begin
			pend_kind_q <= e_kind;
			pend_slot_q <= e_slot;
			pend_play_q <= e_play;
			pend_stat_q <= e_stat;
		end
		if (out_load) begin
			out_kind_q <= pend_kind_q;
			out_slot_q <= pend_slot_q;
			out_play_q <= pend_play_q;
			out_stat_q <= pend_stat_q;
			out_free_q <= free_count_q;
			out_last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_type_q   <= ESM_TYPE_RST;
			alloc_q      <= '0;
			play_q       <= '0;
			free_count_q <= 7'(SLOTS - ESM_FIRST_SLOT);
			time_q       <= '0;
			cnt_q        <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_type_q <= cfg_wdata;
			end
			if (go) begin
				if (a_set) begin
					alloc_q[f_idx] <= 1'b1;
				end
				if (a_clr) begin
					alloc_q[f_idx] <= 1'b0;
				end
				if (p_set) begin
					play_q[f_idx] <= 1'b1;
				end
				if (p_clr) begin
					play_q[f_idx] <= 1'b0;
				end
				if (fc_inc) begin
					free_count_q <= free_count_q + 1'b1;
				end
				if (fc_dec) begin
					free_count_q <= free_count_q - 1'b1;
				end
				if (time_inc) begin
					time_q <= time_q + 1'b1;
				end
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (go && emit_req) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (go && emit_req) begin
				pend_v_q <= 1'b1;
			end else if (out_load) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'd0, out_free_q, out_stat_q, out_play_q, out_slot_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	`ESM_ASSERT(a_free_count, ($countones(alloc_q) + int'(free_count_q)) == (SLOTS - ESM_FIRST_SLOT), "free count disagrees with allocation flags")
	`ESM_ASSERT_NEVER(a_play_alloc, (play_q & ~alloc_q) != '0, "playing slot is not allocated")
	`ESM_ASSERT(a_flush_empty, (cmd.flush && !blk) |=> !pend_v_q, "pending result left after flush")
	`ESM_ASSERT_NEVER(a_cnt_range, cnt_q > ESM_CNT_W'(ESM_MAX_RESULTS), "result count beyond limit")
endmodule

@@ design/effect_slot_manager_core.sv @@
// Effect slot manager: a table of SLOTS effect slots (slots 0 and 1 reserved) driven by
// one command per input transaction. Free, start, stop, set_duration and a create with a
// rejected type run without a scan; create, free_all, solo and tick scan the slots one at a
// time, each slot through a read state and an evaluate state for the registered read of the
// start time and duration RAMs (create ends at the first free slot, solo then starts its own
// slot in a further state), and the result side can stall the sequence.
module effect_slot_manager_core import esm_pkg::*; #(
	parameter int SLOTS = ESM_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // effect_index, effect_type, duration_value
	input  logic [2:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // slot_index, is_playing, load_status, slots_free
	output logic        m_axis_tuser,  // report_kind
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	esm_cmd_t                 cmd;
	esm_sts_t                 sts;
	logic [$clog2(SLOTS)-1:0] scan_idx;

	esm_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cmd           (cmd),
		.sts           (sts),
		.scan_idx      (scan_idx)
	);

	esm_dp #(.SLOTS(SLOTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.scan_idx      (scan_idx),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);
endmodule
